[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the reassembly tracker.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srt assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srt assertion failed");

`endif

[rtl/core/srt_pkg.sv]
// Types and codes of the sub-packet reassembly tracker.
// Used by srt_step, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package srt_pkg;

  localparam int MASK_W   = 64;
  localparam int TOTAL_W  = 13;
  localparam int OFFSET_W = 12;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'd8191;

  localparam logic [1:0] CMD_SUBPACKET = 2'd0;
  localparam logic [1:0] CMD_TICK      = 2'd1;
  localparam logic [1:0] CMD_START     = 2'd2;

  localparam logic [1:0] CFG_PACKET_ID  = 2'd0;
  localparam logic [1:0] CFG_SUBPACKETS = 2'd1;
  localparam logic [1:0] CFG_RETRY      = 2'd2;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_DUP       = 3'd1,
    ST_WRONG_ID  = 3'd2,
    ST_REQUEST   = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_IDLE      = 3'd5,
    ST_STARTED   = 3'd6
  } srt_status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pkt_id;
    logic [5:0]  sub_index;
    logic [6:0]  sub_count;
    logic [6:0]  byte_count;
  } srt_item_t;

  typedef struct packed {
    logic [15:0] expected_pkt_id;
    logic [6:0]  expected_subpackets;
    logic [3:0]  retry_limit;
  } srt_cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0]  bitmap;
    logic [TOTAL_W-1:0] total;
    logic [3:0]         retries;
    logic               active;
  } srt_state_t;

  typedef struct packed {
    srt_status_t         status;
    logic [OFFSET_W-1:0] write_offset;
    logic [MASK_W-1:0]   request_mask;
    logic                complete;
    logic [TOTAL_W-1:0]  total_bytes;
  } srt_result_t;

endpackage

[rtl/core/srt_step.sv]
// Per-word decision logic of the reassembly tracker: result and next state.
// Pure combinational; depends on srt_pkg.
`timescale 1ns / 1ps

module srt_step #(
  parameter int SUBPACKET_BYTES = 64,
  parameter int MAX_SUBPACKETS  = 64
) (
  input  srt_pkg::srt_item_t   item,
  input  srt_pkg::srt_cfg_t    cfg,
  input  srt_pkg::srt_state_t  state,
  output srt_pkg::srt_result_t result,
  output srt_pkg::srt_state_t  state_next
);

  localparam int PROD_W = 6 + $clog2(SUBPACKET_BYTES + 1);
  localparam logic [6:0] MAX_CNT = 7'(MAX_SUBPACKETS);

  logic [6:0]                   cnt_sat;
  logic [6:0]                   exp_sat;
  logic [srt_pkg::MASK_W-1:0]   cnt_mask;
  logic [srt_pkg::MASK_W-1:0]   exp_mask;
  logic [srt_pkg::MASK_W-1:0]   bit_sel;
  logic [srt_pkg::MASK_W-1:0]   bitmap_set;
  logic                         idx_ok;
  logic                         seen;
  logic [PROD_W-1:0]            prod;
  logic [srt_pkg::TOTAL_W:0]    sum;
  logic [srt_pkg::TOTAL_W-1:0]  sum_sat;

  always_comb begin
    cnt_sat  = (item.sub_count > MAX_CNT) ? MAX_CNT : item.sub_count;
    exp_sat  = (cfg.expected_subpackets > MAX_CNT) ? MAX_CNT : cfg.expected_subpackets;
    cnt_mask = (cnt_sat >= 7'd64) ? '1 : ((64'd1 << cnt_sat) - 64'd1);
    exp_mask = (exp_sat >= 7'd64) ? '1 : ((64'd1 << exp_sat) - 64'd1);
    idx_ok   = {1'b0, item.sub_index} < MAX_CNT;
    bit_sel  = 64'd1 << item.sub_index;
    seen     = (state.bitmap & bit_sel) != '0;
    bitmap_set = state.bitmap | bit_sel;
    prod     = PROD_W'(item.sub_index) * PROD_W'(SUBPACKET_BYTES);
    sum      = {1'b0, state.total} + (srt_pkg::TOTAL_W + 1)'(item.byte_count);
    sum_sat  = sum[srt_pkg::TOTAL_W] ? srt_pkg::TOTAL_MAX : sum[srt_pkg::TOTAL_W-1:0];
  end

  always_comb begin
    state_next          = state;
    result.status       = srt_pkg::ST_IDLE;
    result.write_offset = '0;
    result.request_mask = '0;
    result.complete     = 1'b0;
    case (item.cmd)
      srt_pkg::CMD_START: begin
        state_next.bitmap  = '0;
        state_next.total   = '0;
        state_next.retries = cfg.retry_limit;
        state_next.active  = 1'b1;
        result.status      = srt_pkg::ST_STARTED;
      end
      srt_pkg::CMD_SUBPACKET: begin
        if (state.active) begin
          if (item.pkt_id != cfg.expected_pkt_id) begin
            state_next.active = 1'b0;
            result.status     = srt_pkg::ST_WRONG_ID;
          end else if (!idx_ok || seen) begin
            result.status = srt_pkg::ST_DUP;
          end else begin
            state_next.bitmap   = bitmap_set;
            state_next.total    = sum_sat;
            result.status       = srt_pkg::ST_STORED;
            result.write_offset = srt_pkg::OFFSET_W'(prod);
            if (bitmap_set == cnt_mask) begin
              result.complete   = 1'b1;
              state_next.active = 1'b0;
            end
          end
        end
      end
      srt_pkg::CMD_TICK: begin
        if (state.active) begin
          if (state.retries != 4'd0) begin
            result.request_mask = ~state.bitmap & exp_mask;
            state_next.retries  = state.retries - 4'd1;
            result.status       = srt_pkg::ST_REQUEST;
          end else begin
            state_next.active = 1'b0;
            result.status     = srt_pkg::ST_EXHAUSTED;
          end
        end
      end
      default: begin
        result.status = srt_pkg::ST_IDLE;
      end
    endcase
    result.total_bytes = state_next.total;
  end

endmodule

[rtl/core/subpacket_reassembly_tracker.sv]
// Top level of the sub-packet reassembly tracker: stream ports, registers, state.
// Depends on srt_pkg and srt_step.
// A word accepted is held in the input register; its result is loaded into the
// output register once that register is free or being read, and shown from then on.
// Throughput: one word per cycle unless m_tready stalls the output; bitmap and total update as each word advances.
// Reset (rst, synchronous, active high): tracker idle, bitmap, total and retries
// cleared, registers back to packet id 0, 64 sub-packets, retry limit 4.
`timescale 1ns / 1ps

module subpacket_reassembly_tracker #(
  parameter int SUBPACKET_BYTES = 64,
  parameter int MAX_SUBPACKETS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pkt_id, sub_index, sub_count, byte_count, zero pad
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // write_offset, request_mask, total_bytes, zero pad
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast,   // complete
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  srt_pkg::srt_item_t   item;
  logic                 item_valid;
  srt_pkg::srt_cfg_t    cfg;
  srt_pkg::srt_state_t  state;
  srt_pkg::srt_state_t  state_next;
  srt_pkg::srt_result_t result;
  srt_pkg::srt_result_t out_reg;
  logic                 out_valid;
  logic                 advance;

  logic [MAX_SUBPACKETS-1:0] bitmap;
  logic [12:0]               total;
  logic [3:0]                retries;
  logic                      active;

  assign advance   = item_valid && (!out_valid || m_tready);
  assign s_tready  = !item_valid || advance;
  assign cfg_ready = 1'b1;

  assign state.bitmap  = srt_pkg::MASK_W'(bitmap);
  assign state.total   = total;
  assign state.retries = retries;
  assign state.active  = active;

  srt_step #(
    .SUBPACKET_BYTES(SUBPACKET_BYTES),
    .MAX_SUBPACKETS (MAX_SUBPACKETS)
  ) u_step (
    .item      (item),
    .cfg       (cfg),
    .state     (state),
    .result    (result),
    .state_next(state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.cmd        <= s_tuser;
      item.pkt_id     <= s_tdata[15:0];
      item.sub_index  <= s_tdata[21:16];
      item.sub_count  <= s_tdata[28:22];
      item.byte_count <= s_tdata[35:29];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap  <= '0;
      total   <= '0;
      retries <= '0;
      active  <= 1'b0;
    end else if (advance) begin
      bitmap  <= state_next.bitmap[MAX_SUBPACKETS-1:0];
      total   <= state_next.total;
      retries <= state_next.retries;
      active  <= state_next.active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_pkt_id     <= 16'd0;
      cfg.expected_subpackets <= 7'd64;
      cfg.retry_limit         <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srt_pkg::CFG_PACKET_ID:  cfg.expected_pkt_id     <= cfg_data;
        srt_pkg::CFG_SUBPACKETS: cfg.expected_subpackets <= cfg_data[6:0];
        srt_pkg::CFG_RETRY:      cfg.retry_limit         <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_reg.status;
  assign m_tlast  = out_reg.complete;
  assign m_tdata  = {7'd0, out_reg.total_bytes, out_reg.request_mask, out_reg.write_offset};

endmodule

[rtl/core/srt_checker.sv]
// Port-level checker for the reassembly tracker, bound to the top level.
// Depends on srt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srt_port_assert (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  logic stalled;
  logic is_stored;
  logic is_request;

  assign stalled    = m_tvalid && !m_tready;
  assign is_stored  = m_tuser == srt_pkg::ST_STORED;
  assign is_request = m_tuser == srt_pkg::ST_REQUEST;

  `SRT_ASSERT_NEXT(a_stall_hold, clk, rst, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `SRT_ASSERT_IMPLY(a_complete_stored, clk, rst, m_tvalid && m_tlast, is_stored)
  `SRT_ASSERT_IMPLY(a_mask_request, clk, rst, m_tvalid && (m_tdata[75:12] != 64'd0), is_request)
  `SRT_ASSERT_IMPLY(a_offset_stored, clk, rst, m_tvalid && (m_tdata[11:0] != 12'd0), is_stored)

endmodule

bind subpacket_reassembly_tracker srt_port_assert u_srt_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
